// ----- design/rfa_pkg.sv -----
// Shared types and constants for the rational fraction ALU.
package rfa_pkg;
    localparam int WORD_W = 64;

    localparam logic [1:0] FUNC_ADD  = 2'd0;
    localparam logic [1:0] FUNC_MUL  = 2'd1;
    localparam logic [1:0] FUNC_DIV  = 2'd2;
    localparam logic [1:0] FUNC_NONE = 2'd3;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } frac_in_t;

    typedef struct packed {
        logic signed [63:0] res_num;
        logic signed [63:0] res_den;
        logic               error;
    } frac_out_t;

    typedef struct packed {
        logic  start;
        word_t dividend;
        word_t divisor;
    } div_req_t;

    typedef struct packed {
        logic  done;
        word_t quot;
        word_t rem;
    } div_rsp_t;
endpackage

// ----- design/rfa_if.sv -----
// Valid/ready channel interface carrying one payload word.
interface rfa_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- design/rfa_div.sv -----
// Shared 64-bit unsigned restoring divider, one quotient bit per cycle.
module rfa_div (
    input  logic              clk,
    input  logic              rst_n,
    input  rfa_pkg::div_req_t req,
    output rfa_pkg::div_rsp_t rsp
);
    import rfa_pkg::*;

    logic [WORD_W:0]         rem_reg, rem_next;
    word_t                   quo_reg, quo_next;
    word_t                   dvs_reg, dvs_next;
    logic [6:0]              cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [WORD_W:0]         trial;
    logic [WORD_W:0]         shifted;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[WORD_W-1:0], quo_reg[WORD_W-1]};
        trial     = shifted - {1'b0, dvs_reg};
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
            cnt_next  = 7'(WORD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[WORD_W])
            begin
                rem_next = trial;
                quo_next = {quo_reg[WORD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[WORD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg[WORD_W-1:0];
endmodule

// ----- design/rational_fraction_alu.sv -----
// Exact rational add/multiply/divide with Euclidean GCD reduction.
// One fraction pair is taken at a time; in_ready is low until its result
// word is loaded into the output register, which happens once the previous
// result word has left. All division work (Euclid remainders, the
// LCM quotient, the two scale quotients and the final two reductions) runs
// on one shared bit-serial divider: multiply and divide need (Euclid steps
// + 2) divisions, add needs (Euclid steps on the denominators + 3) plus
// (Euclid steps on the result + 2), worst case about 140 divisions for an
// add. Error cases skip the divider and pass from S_PREP through S_OUT and
// S_WAIT before their result word is loaded. Operands are OPERAND_WIDTH-bit
// two's complement from the low field bits.
module rational_fraction_alu #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic clk,
    input  logic rst_n,
    rfa_if.sink   in_ch,
    rfa_if.source out_ch
);
    import rfa_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PREP = 4'd1;
    localparam logic [3:0] S_G1   = 4'd2;
    localparam logic [3:0] S_LCM  = 4'd3;
    localparam logic [3:0] S_QA   = 4'd4;
    localparam logic [3:0] S_QB   = 4'd5;
    localparam logic [3:0] S_SUM  = 4'd6;
    localparam logic [3:0] S_G2   = 4'd7;
    localparam logic [3:0] S_RN   = 4'd8;
    localparam logic [3:0] S_RD   = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;
    localparam logic [3:0] S_WAIT = 4'd11;
    localparam logic [3:0] S_MULA = 4'd12;
    localparam logic [3:0] S_MULB = 4'd13;
    localparam logic [3:0] S_SUMA = 4'd14;

    logic [3:0] st_reg, st_next;
    logic       busy_reg, busy_next;
    word_t an_reg, ad_reg, bn_reg, bd_reg;
    word_t an_next, ad_next, bn_next, bd_next;
    word_t rn_reg, rd_reg, rn_next, rd_next;
    word_t x_reg, y_reg, x_next, y_next;
    word_t t_reg, t_next;
    logic  ov_reg, ov_next;
    logic  err_reg, err_next;
    logic  [1:0] fn_reg, fn_next;
    word_t onum_reg, oden_reg, onum_next, oden_next;
    logic  oerr_reg, oerr_next;
    logic  ovalid_reg, ovalid_next;
    div_req_t dreq;
    div_rsp_t drsp;

    function automatic word_t sx(input logic [31:0] v);
        logic [OPERAND_WIDTH-1:0] t;
        t = v[OPERAND_WIDTH-1:0];
        return word_t'(signed'(t));
    endfunction

    function automatic word_t mag(input word_t v);
        return v[WORD_W-1] ? word_t'(-v) : v;
    endfunction

    function automatic word_t sneg(input word_t v, input logic n);
        return n ? word_t'(-v) : v;
    endfunction

    rfa_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    logic [32:0] m_a, m_b;
    logic [63:0] m_p;
    // 33x33 signed multiplier (scale quotients reach +2^31), registered by the caller.
    assign m_p = 64'(signed'({{31{m_a[32]}}, m_a}) * signed'({{31{m_b[32]}}, m_b}));

    always_comb
    begin
        st_next = st_reg; busy_next = busy_reg;
        an_next = an_reg; ad_next = ad_reg; bn_next = bn_reg; bd_next = bd_reg;
        rn_next = rn_reg; rd_next = rd_reg; x_next = x_reg; y_next = y_reg;
        t_next = t_reg; ov_next = ov_reg; err_next = err_reg; fn_next = fn_reg;
        onum_next = onum_reg; oden_next = oden_reg; oerr_next = oerr_reg;
        ovalid_next = ovalid_reg;
        dreq = '0;
        m_a = '0; m_b = '0;
        if (out_ch.valid && out_ch.ready)
            ovalid_next = 1'b0;
        case (st_reg)
            S_IDLE:
            begin
                if (in_ch.valid && !busy_reg)
                begin
                    fn_next = in_ch.data.func;
                    an_next = sx(in_ch.data.a_num);
                    ad_next = sx(in_ch.data.a_den);
                    bn_next = sx(in_ch.data.b_num);
                    bd_next = sx(in_ch.data.b_den);
                    busy_next = 1'b1;
                    st_next = S_PREP;
                end
            end
            S_PREP:
            begin
                if (ad_reg == '0 || bd_reg == '0 || fn_reg == FUNC_NONE ||
                    (fn_reg == FUNC_DIV && bn_reg == '0))
                begin
                    rn_next = '0; rd_next = '0; err_next = 1'b1;
                    st_next = S_OUT;
                end
                else
                begin
                    err_next = 1'b0;
                    if (fn_reg == FUNC_ADD)
                    begin
                        x_next = mag(ad_reg); y_next = mag(bd_reg);
                        ov_next = 1'b1;
                        st_next = S_G1;
                    end
                    else
                        st_next = S_MULA;
                end
            end
            S_MULA:
            begin
                m_a = an_reg[32:0];
                m_b = (fn_reg == FUNC_MUL) ? bn_reg[32:0] : bd_reg[32:0];
                t_next = m_p;
                st_next = S_MULB;
            end
            S_MULB:
            begin
                m_a = ad_reg[32:0];
                m_b = (fn_reg == FUNC_MUL) ? bd_reg[32:0] : bn_reg[32:0];
                if (fn_reg == FUNC_DIV && m_p[63])
                begin
                    rd_next = word_t'(-m_p); rn_next = word_t'(-t_reg);
                end
                else
                begin
                    rd_next = m_p; rn_next = t_reg;
                end
                x_next = mag(rn_next); y_next = mag(rd_next);
                st_next = S_G2;
            end
            // Euclid on the denominator magnitudes.
            S_G1:
            begin
                if (y_reg == '0)
                begin
                    m_a = ad_reg[32:0]; m_b = bd_reg[32:0];
                    dreq.start = 1'b1; dreq.dividend = mag(m_p); dreq.divisor = x_reg;
                    st_next = S_LCM;
                    ov_next = 1'b1;
                end
                else if (ov_reg)
                begin
                    dreq.start = 1'b1; dreq.dividend = x_reg; dreq.divisor = y_reg;
                    ov_next = 1'b0;
                end
                else if (drsp.done)
                begin
                    x_next = y_reg; y_next = drsp.rem; ov_next = 1'b1;
                end
            end
            S_LCM:
            begin
                ov_next = 1'b0;
                if (drsp.done && !ov_reg)
                begin
                    rd_next = drsp.quot;
                    dreq.start = 1'b1; dreq.dividend = drsp.quot;
                    dreq.divisor = mag(ad_reg);
                    ov_next = 1'b1;
                    st_next = S_QA;
                end
            end
            S_QA:
            begin
                ov_next = 1'b0;
                if (drsp.done && !ov_reg)
                begin
                    t_next = sneg(drsp.quot, ad_reg[WORD_W-1]);
                    dreq.start = 1'b1; dreq.dividend = rd_reg;
                    dreq.divisor = mag(bd_reg);
                    ov_next = 1'b1;
                    st_next = S_QB;
                end
            end
            S_QB:
            begin
                ov_next = 1'b0;
                if (drsp.done && !ov_reg)
                begin
                    y_next = sneg(drsp.quot, bd_reg[WORD_W-1]);
                    st_next = S_SUMA;
                end
            end
            S_SUMA:
            begin
                // qa and qb lie in [-2^31, 2^31], so 33 bits carry them exactly.
                m_a = an_reg[32:0]; m_b = t_reg[32:0];
                x_next = m_p;
                st_next = S_SUM;
            end
            S_SUM:
            begin
                m_a = bn_reg[32:0]; m_b = y_reg[32:0];
                rn_next = x_reg + m_p;
                x_next = mag(x_reg + m_p); y_next = mag(rd_reg);
                st_next = S_G2;
            end
            S_G2:
            begin
                if (y_reg == '0)
                begin
                    if (x_reg == '0)
                        st_next = S_OUT;
                    else
                    begin
                        dreq.start = 1'b1; dreq.dividend = mag(rn_reg);
                        dreq.divisor = x_reg;
                        ov_next = 1'b1;
                        st_next = S_RN;
                    end
                end
                else if (!ov_reg)
                begin
                    dreq.start = 1'b1; dreq.dividend = x_reg; dreq.divisor = y_reg;
                    ov_next = 1'b1;
                end
                else if (drsp.done)
                begin
                    x_next = y_reg; y_next = drsp.rem; ov_next = 1'b0;
                end
            end
            S_RN:
            begin
                ov_next = 1'b0;
                if (drsp.done && !ov_reg)
                begin
                    rn_next = sneg(drsp.quot, rn_reg[WORD_W-1]);
                    dreq.start = 1'b1; dreq.dividend = mag(rd_reg);
                    dreq.divisor = x_reg;
                    ov_next = 1'b1;
                    st_next = S_RD;
                end
            end
            S_RD:
            begin
                ov_next = 1'b0;
                if (drsp.done && !ov_reg)
                begin
                    rd_next = sneg(drsp.quot, rd_reg[WORD_W-1]);
                    st_next = S_OUT;
                end
            end
            S_OUT:
            begin
                st_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (!ovalid_next)
                begin
                    onum_next = rn_reg; oden_next = rd_reg; oerr_next = err_reg;
                    ovalid_next = 1'b1;
                    busy_next = 1'b0;
                    ov_next = 1'b0;
                    st_next = S_IDLE;
                end
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= S_IDLE;
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            st_reg     <= st_next;
            busy_reg   <= busy_next;
            ovalid_reg <= ovalid_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        an_reg <= an_next; ad_reg <= ad_next; bn_reg <= bn_next; bd_reg <= bd_next;
        rn_reg <= rn_next; rd_reg <= rd_next; x_reg <= x_next; y_reg <= y_next;
        t_reg <= t_next; err_reg <= err_next; fn_reg <= fn_next;
        onum_reg <= onum_next; oden_reg <= oden_next; oerr_reg <= oerr_next;
    end

    assign in_ch.ready  = (st_reg == S_IDLE) && !busy_reg;
    assign out_ch.valid = ovalid_reg;
    assign out_ch.data  = frac_out_t'{onum_reg, oden_reg, oerr_reg};
endmodule

// ----- design/rfa_checker.sv -----
// Port-level checker for the rational fraction ALU, bound to the top level.
module rfa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] res_den,
    input logic        error
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");
    a_err_den: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> res_den == 64'd0)
        else $error("error result with nonzero denominator");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in flight");
    a_ok_den: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !error |-> res_den != 64'd0)
        else $error("valid result with zero denominator");
endmodule

bind rational_fraction_alu rfa_checker u_rfa_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .res_den(out_ch.data.res_den), .error(out_ch.data.error)
);
